FILE: rtl/core/tlsm_pkg.sv
// Package: shared constants and controller/datapath interface types for the list merge.
`default_nettype none
package tlsm_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 32;
    localparam int M_TUSER_W      = 2;

    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic last;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/core/tlsm_ctrl.sv
// Controller: sequences loading, head prefetch and the merge run.
`default_nettype none
module tlsm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_end,
    input  tlsm_pkg::t_sts     i_sts,
    output logic               o_in_ready,
    output tlsm_pkg::t_cmd     o_cmd
);
    import tlsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_MERGE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_end) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tlsm_dpath.sv
// Datapath: list memories, fill/length counters, head compare and output register.
`default_nettype none
module tlsm_dpath #(
    parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  tlsm_pkg::t_cmd                             i_cmd,
    input  wire logic                                  i_sel,
    input  wire logic signed [tlsm_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                                  i_has,
    input  wire logic                                  i_end,
    input  wire logic                                  i_out_ready,
    output tlsm_pkg::t_sts                             o_sts,
    output logic                                       o_out_valid,
    output logic signed [tlsm_pkg::VALUE_W-1:0]        o_value,
    output logic                                       o_empty,
    output logic                                       o_trunc,
    output logic                                       o_last
);
    import tlsm_pkg::*;

    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int TW = LW + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(LIST_DEPTH);

    logic signed [VALUE_W-1:0] r_mem1 [LIST_DEPTH];
    logic signed [VALUE_W-1:0] r_mem2 [LIST_DEPTH];

    logic [LW-1:0] r_fill1, n_fill1, r_fill2, n_fill2;
    logic [LW-1:0] r_len1, n_len1, r_len2, n_len2;
    logic [1:0]    r_ovf, n_ovf;
    logic          we1, we2;

    logic [LW-1:0] r_i1, n_i1, r_i2, n_i2;
    logic [TW-1:0] r_left, n_left;
    logic signed [VALUE_W-1:0] r_h1, r_h2;
    logic          take1;
    logic          out_free;

    always_comb begin
        n_fill1 = r_fill1;
        n_fill2 = r_fill2;
        n_len1  = r_len1;
        n_len2  = r_len2;
        n_ovf   = r_ovf;
        we1     = 1'b0;
        we2     = 1'b0;
        if (i_cmd.load) begin
            if (i_has) begin
                if (i_sel == SEL_FIRST) begin
                    if (r_fill1 == '0) begin
                        n_ovf[0] = 1'b0;
                    end
                    if (r_fill1 < DEPTH_L) begin
                        we1     = 1'b1;
                        n_fill1 = r_fill1 + 1'b1;
                    end else begin
                        n_ovf[0] = 1'b1;
                    end
                end else begin
                    if (r_fill2 == '0) begin
                        n_ovf[1] = 1'b0;
                    end
                    if (r_fill2 < DEPTH_L) begin
                        we2     = 1'b1;
                        n_fill2 = r_fill2 + 1'b1;
                    end else begin
                        n_ovf[1] = 1'b1;
                    end
                end
            end
            if (i_end) begin
                if (i_sel == SEL_FIRST) begin
                    if (n_fill1 == '0) begin
                        n_ovf[0] = 1'b0;
                    end
                    n_len1  = n_fill1;
                    n_fill1 = '0;
                end else begin
                    if (n_fill2 == '0) begin
                        n_ovf[1] = 1'b0;
                    end
                    n_len2  = n_fill2;
                    n_fill2 = '0;
                end
            end
        end
    end

    assign out_free = !o_out_valid || i_out_ready;
    assign take1    = (r_i2 == r_len2) || ((r_i1 != r_len1) && (r_h1 <= r_h2));

    always_comb begin
        n_i1   = r_i1;
        n_i2   = r_i2;
        n_left = r_left;
        if (i_cmd.prep) begin
            n_i1   = '0;
            n_i2   = '0;
            n_left = TW'(r_len1) + TW'(r_len2);
        end else if (i_cmd.step) begin
            if (take1) begin
                n_i1 = r_i1 + 1'b1;
            end else begin
                n_i2 = r_i2 + 1'b1;
            end
            n_left = r_left - 1'b1;
        end
    end

    assign o_sts.out_free = out_free;
    assign o_sts.empty    = (r_len1 == '0) && (r_len2 == '0);
    assign o_sts.last     = (r_left == TW'(1));

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[r_fill1[AW-1:0]] <= i_value;
        end
        if (we2) begin
            r_mem2[r_fill2[AW-1:0]] <= i_value;
        end
        r_h1 <= r_mem1[n_i1[AW-1:0]];
        r_h2 <= r_mem2[n_i2[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill1     <= '0;
            r_fill2     <= '0;
            r_len1      <= '0;
            r_len2      <= '0;
            r_ovf       <= '0;
            r_i1        <= '0;
            r_i2        <= '0;
            r_left      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_fill1 <= n_fill1;
            r_fill2 <= n_fill2;
            r_len1  <= n_len1;
            r_len2  <= n_len2;
            r_ovf   <= n_ovf;
            r_i1    <= n_i1;
            r_i2    <= n_i2;
            r_left  <= n_left;
            if (i_cmd.step || i_cmd.emit_empty) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_value <= take1 ? r_h1 : r_h2;
            o_empty <= 1'b0;
            o_trunc <= |r_ovf;
            o_last  <= (r_left == TW'(1));
        end else if (i_cmd.emit_empty) begin
            o_value <= '0;
            o_empty <= 1'b1;
            o_trunc <= |r_ovf;
            o_last  <= 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/two_list_sorted_merge.sv
// Top level: two-way merge of two stored sorted lists over stream channels.
//
//  channel  | dir | tdata                                     | tuser                    | tlast
//  s_axis   | in  | [31:0] element_value, [32] has_element     | [0] operation            | message_end
//  m_axis   | out | [31:0] merged_value                        | [0] merge_empty, [1] truncated | last_of_run
//
// Loading takes one beat per cycle. A beat with tlast starts the head prefetch, then the
// merge issues one result per cycle unless the output stalls (n1 + n2 results, or one empty
// result), set by the single read port of each list memory. Input is refused from the closing
// beat until the last result is loaded into the output register, which holds under stall.
// Reset is synchronous and clears counters, lengths and flags; list contents are not cleared.
`default_nettype none
module two_list_sorted_merge #(
    parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [tlsm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] element_value, [32] has_element
    input  wire logic                             s_axis_tuser,  // [0] operation
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [tlsm_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [31:0] merged_value
    output logic [tlsm_pkg::M_TUSER_W-1:0]        m_axis_tuser,  // [0] merge_empty, [1] truncated
    output logic                                  m_axis_tlast
);
    import tlsm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic signed [VALUE_W-1:0] out_value;
    logic out_empty;
    logic out_trunc;

    tlsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_end   (s_axis_tlast),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tlsm_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sel       (s_axis_tuser),
        .i_value     ($signed(s_axis_tdata[VALUE_W-1:0])),
        .i_has       (s_axis_tdata[VALUE_W]),
        .i_end       (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_value     (out_value),
        .o_empty     (out_empty),
        .o_trunc     (out_trunc),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = out_value;
    assign m_axis_tuser = {out_trunc, out_empty};

endmodule
`default_nettype wire

FILE: rtl/core/tlsm_checker.sv
// Checker: port-level properties of the list merge, bound to the top level.
`default_nettype none
module tlsm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after a closing beat");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 32'd0))
        else $error("empty result not a lone zero beat");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted during a merge run");

endmodule

bind two_list_sorted_merge tlsm_checker u_tlsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
